/* src/stok_pkg.sv */
// ----------------------------------------------------------------------------
// stok_pkg
// Types, character codes and keyword table shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int LEN_W      = 6;
  localparam int KW_NUM     = 21;
  localparam int KW_TEXT_W  = 88;

  typedef logic [LEN_W-1:0]  tok_len_t;
  typedef logic [KW_NUM-1:0] kw_mask_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [2:0] {
    TT_KEYWORD = 3'd0,
    TT_SYMBOL  = 3'd1,
    TT_INTEGER = 3'd2,
    TT_STRING  = 3'd3,
    TT_IDENT   = 3'd4
  } tok_type_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BYTE   = 2'd1,
    ERR_STRING = 2'd2,
    ERR_LONG   = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_WORD  = 3'd1,
    M_INT   = 3'd2,
    M_STR   = 3'd3,
    M_SLASH = 3'd4,
    M_LINE  = 3'd5,
    M_BLOCK = 3'd6,
    M_HALT  = 3'd7
  } mode_t;

  // What the back end emits ahead of the optional single result.
  typedef enum logic [1:0] {
    FK_NONE  = 2'd0,
    FK_FLUSH = 2'd1,
    FK_SLASH = 2'd2
  } first_t;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_FETCH  = 3'd1,
    BK_EMIT   = 3'd2,
    BK_SLASH  = 3'd3,
    BK_SINGLE = 3'd4
  } back_st_t;

  typedef struct packed {
    tok_type_t   tok_type;
    logic [7:0]  tok_char;
    logic        char_valid;
    logic        last;
    err_t        err;
  } result_t;

  typedef struct packed {
    first_t      first;
    tok_type_t   flush_type;
    tok_len_t    flush_len;
    logic        flush_bank;
    logic        has_single;
    result_t     single;
  } cmd_t;

  typedef struct packed {
    logic        en;
    logic        bank;
    tok_len_t    pos;
    logic [7:0]  data;
  } wr_t;

  typedef struct packed {
    logic        en;
    logic        bank;
  } rel_t;

  // Keywords, right-justified in 88 bits, with their lengths.
  localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_NUM] = '{
    "class", "constructor", "function", "method", "field", "static", "var",
    "int", "char", "boolean", "void", "true", "false", "null", "this",
    "let", "do", "if", "else", "while", "return"
  };

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd5, 4'd11, 4'd8, 4'd6, 4'd5, 4'd6, 4'd3,
    4'd3, 4'd4, 4'd7, 4'd4, 4'd4, 4'd5, 4'd4, 4'd4,
    4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd6
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

  function automatic logic is_line_end(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c inside {"{", "}", "(", ")", "[", "]", ".", ",", ";", "+", "-",
                     "*", "/", "&", "|", "<", ">", "=", "~"};
  endfunction

  // Narrow the keyword candidates by the character placed at pos.
  function automatic kw_mask_t kw_step(input kw_mask_t m, input tok_len_t pos,
                                       input logic [7:0] c);
    kw_mask_t r;
    int       sh;
    r = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      sh = (int'(KW_LEN[k]) - 1 - int'(pos)) * 8;
      if (m[k] && (int'(pos) < int'(KW_LEN[k]))) begin
        r[k] = (KW_TEXT[k][sh +: 8] == c);
      end
    end
    return r;
  endfunction

  function automatic logic kw_hit(input kw_mask_t m, input tok_len_t len);
    logic h;
    h = 1'b0;
    for (int k = 0; k < KW_NUM; k++) begin
      h = h | (m[k] && ({2'b00, KW_LEN[k]} == len));
    end
    return h;
  endfunction

endpackage

/* src/stok_queue.sv */
// ----------------------------------------------------------------------------
// stok_queue
// Two-entry command queue between the scanner and the emitter.
// ----------------------------------------------------------------------------
module stok_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  stok_pkg::cmd_t  push_data,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output stok_pkg::cmd_t  pop_data
);

  stok_pkg::cmd_t ent_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* src/stok_front.sv */
// ----------------------------------------------------------------------------
// stok_front
// Scanner: tracks the scan mode, writes token text into the current buffer
// bank, matches keywords on the fly and issues at most one command per byte.
// ----------------------------------------------------------------------------
module stok_front #(
  parameter int MAX_TOKEN = 63
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tuser,
  output logic            push,
  output stok_pkg::cmd_t  cmd,
  input  logic            q_ready,
  output stok_pkg::wr_t   wr,
  input  stok_pkg::rel_t  rel
);

  stok_pkg::mode_t    mode_r, mode_nxt;
  stok_pkg::tok_len_t len_r, len_nxt;
  logic               star_r, star_nxt;
  logic               bank_r, bank_nxt;
  logic [1:0]         busy_r;
  stok_pkg::kw_mask_t match_r, match_nxt;

  logic       take, eot, scan, full, alnum;
  logic [7:0] c;

  assign c     = in_tdata;
  assign eot   = in_tuser;
  assign take  = in_tvalid && in_tready;
  assign full  = (len_r == stok_pkg::tok_len_t'(MAX_TOKEN));
  assign alnum = stok_pkg::is_letter(c) || stok_pkg::is_digit(c);

  // Hold input while the queue is full or the bank the next token would use is still draining.
  assign in_tready = q_ready && !busy_r[~bank_r];

  // The byte is scanned as the start of a new token.
  assign scan = take && !eot &&
                ((mode_r == stok_pkg::M_IDLE) ||
                 ((mode_r == stok_pkg::M_WORD) && !alnum) ||
                 ((mode_r == stok_pkg::M_INT) && !stok_pkg::is_digit(c)) ||
                 ((mode_r == stok_pkg::M_SLASH) && (c != stok_pkg::CH_SLASH) &&
                  (c != stok_pkg::CH_STAR)));

  always_comb begin
    mode_nxt = mode_r;
    if (take && (mode_r != stok_pkg::M_HALT)) begin
      if (eot) begin
        mode_nxt = (mode_r == stok_pkg::M_STR) ? stok_pkg::M_HALT : stok_pkg::M_IDLE;
      end else if (scan) begin
        if (stok_pkg::is_blank(c))            mode_nxt = stok_pkg::M_IDLE;
        else if (c == stok_pkg::CH_SLASH)     mode_nxt = stok_pkg::M_SLASH;
        else if (stok_pkg::is_symbol(c))      mode_nxt = stok_pkg::M_IDLE;
        else if (stok_pkg::is_digit(c))       mode_nxt = stok_pkg::M_INT;
        else if (stok_pkg::is_letter(c))      mode_nxt = stok_pkg::M_WORD;
        else if (c == stok_pkg::CH_QUOTE)     mode_nxt = stok_pkg::M_STR;
        else                                  mode_nxt = stok_pkg::M_HALT;
      end else begin
        unique case (mode_r) inside
          stok_pkg::M_WORD, stok_pkg::M_INT: begin
            if (full) mode_nxt = stok_pkg::M_HALT;
          end
          stok_pkg::M_STR: begin
            if (c == stok_pkg::CH_QUOTE)         mode_nxt = stok_pkg::M_IDLE;
            else if (stok_pkg::is_line_end(c))   mode_nxt = stok_pkg::M_HALT;
            else if (full)                       mode_nxt = stok_pkg::M_HALT;
          end
          stok_pkg::M_SLASH: begin
            mode_nxt = (c == stok_pkg::CH_SLASH) ? stok_pkg::M_LINE : stok_pkg::M_BLOCK;
          end
          stok_pkg::M_LINE: begin
            if (stok_pkg::is_line_end(c)) mode_nxt = stok_pkg::M_IDLE;
          end
          stok_pkg::M_BLOCK: begin
            if (star_r && (c == stok_pkg::CH_SLASH)) mode_nxt = stok_pkg::M_IDLE;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cmd       = '0;
    wr        = '0;
    len_nxt   = len_r;
    star_nxt  = star_r;
    bank_nxt  = bank_r;
    match_nxt = match_r;
    if (take && (mode_r != stok_pkg::M_HALT)) begin
      if (eot) begin
        unique case (mode_r)
          stok_pkg::M_WORD: begin
            cmd.first      = stok_pkg::FK_FLUSH;
            cmd.flush_type = stok_pkg::kw_hit(match_r, len_r) ? stok_pkg::TT_KEYWORD
                                                              : stok_pkg::TT_IDENT;
          end
          stok_pkg::M_INT: begin
            cmd.first      = stok_pkg::FK_FLUSH;
            cmd.flush_type = stok_pkg::TT_INTEGER;
          end
          stok_pkg::M_STR: begin
            cmd.has_single = 1'b1;
            cmd.single.err = stok_pkg::ERR_STRING;
          end
          stok_pkg::M_SLASH: begin
            cmd.first = stok_pkg::FK_SLASH;
          end
          default: ;
        endcase
        len_nxt  = '0;
        star_nxt = 1'b0;
      end else begin
        // close or extend the token in progress
        unique case (mode_r) inside
          stok_pkg::M_WORD, stok_pkg::M_INT: begin
            if (!scan) begin
              if (full) begin
                cmd.has_single = 1'b1;
                cmd.single.err = stok_pkg::ERR_LONG;
              end else begin
                wr        = '{en: 1'b1, bank: bank_r, pos: len_r, data: c};
                len_nxt   = len_r + stok_pkg::tok_len_t'(1);
                match_nxt = stok_pkg::kw_step(match_r, len_r, c);
              end
            end else begin
              cmd.first = stok_pkg::FK_FLUSH;
              if (mode_r == stok_pkg::M_INT) begin
                cmd.flush_type = stok_pkg::TT_INTEGER;
              end else begin
                cmd.flush_type = stok_pkg::kw_hit(match_r, len_r) ? stok_pkg::TT_KEYWORD
                                                                  : stok_pkg::TT_IDENT;
              end
            end
          end
          stok_pkg::M_STR: begin
            if (c == stok_pkg::CH_QUOTE) begin
              if (len_r == '0) begin
                cmd.has_single      = 1'b1;
                cmd.single.tok_type = stok_pkg::TT_STRING;
                cmd.single.last     = 1'b1;
              end else begin
                cmd.first      = stok_pkg::FK_FLUSH;
                cmd.flush_type = stok_pkg::TT_STRING;
              end
              len_nxt = '0;
            end else if (stok_pkg::is_line_end(c)) begin
              cmd.has_single = 1'b1;
              cmd.single.err = stok_pkg::ERR_STRING;
            end else if (full) begin
              cmd.has_single = 1'b1;
              cmd.single.err = stok_pkg::ERR_LONG;
            end else begin
              wr      = '{en: 1'b1, bank: bank_r, pos: len_r, data: c};
              len_nxt = len_r + stok_pkg::tok_len_t'(1);
            end
          end
          stok_pkg::M_SLASH: begin
            if (scan) cmd.first = stok_pkg::FK_SLASH;
            star_nxt = 1'b0;
          end
          stok_pkg::M_BLOCK: begin
            star_nxt = !(star_r && (c == stok_pkg::CH_SLASH)) && (c == stok_pkg::CH_STAR);
          end
          default: ;
        endcase
      end

      if (cmd.first == stok_pkg::FK_FLUSH) begin
        cmd.flush_len  = len_r;
        cmd.flush_bank = bank_r;
        bank_nxt       = ~bank_r;
        len_nxt        = '0;
      end

      // start of a new token
      if (scan) begin
        len_nxt = '0;
        if (stok_pkg::is_blank(c) || (c == stok_pkg::CH_SLASH) ||
            (c == stok_pkg::CH_QUOTE)) begin
          len_nxt = '0;
        end else if (stok_pkg::is_symbol(c)) begin
          cmd.has_single        = 1'b1;
          cmd.single.tok_type   = stok_pkg::TT_SYMBOL;
          cmd.single.tok_char   = c;
          cmd.single.char_valid = 1'b1;
          cmd.single.last       = 1'b1;
        end else if (alnum) begin
          wr        = '{en: 1'b1, bank: bank_nxt, pos: '0, data: c};
          len_nxt   = stok_pkg::tok_len_t'(1);
          match_nxt = stok_pkg::kw_step('1, '0, c);
        end else begin
          cmd.has_single = 1'b1;
          cmd.single.err = stok_pkg::ERR_BYTE;
        end
      end

      if (cmd.has_single && (cmd.single.err != stok_pkg::ERR_NONE)) begin
        len_nxt  = '0;
        star_nxt = 1'b0;
      end
    end
  end

  assign push = (cmd.first != stok_pkg::FK_NONE) || cmd.has_single;

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stok_pkg::M_IDLE;
      len_r  <= '0;
      star_r <= 1'b0;
      bank_r <= 1'b0;
      busy_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      star_r <= star_nxt;
      bank_r <= bank_nxt;
      if (rel.en) busy_r[rel.bank] <= 1'b0;
      if (push && (cmd.first == stok_pkg::FK_FLUSH)) busy_r[cmd.flush_bank] <= 1'b1;
    end
  end

`ifndef SYNTH
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !busy_r[wr.bank])
    else $error("write into a bank that is still being flushed");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == stok_pkg::M_HALT) |-> !push)
    else $error("command issued while halted");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready)
    else $error("command pushed into full queue");
`endif

endmodule

/* src/stok_back.sv */
// ----------------------------------------------------------------------------
// stok_back
// Emitter: holds the two-bank token buffer, pops commands and drives one
// result per transaction through a registered output.
// ----------------------------------------------------------------------------
module stok_back #(
  parameter int MAX_TOKEN = 63
) (
  input  logic             clk,
  input  logic             rst_n,
  input  stok_pkg::wr_t    wr,
  input  logic             q_valid,
  input  stok_pkg::cmd_t   q_data,
  output logic             q_pop,
  output stok_pkg::rel_t   rel,
  output logic             out_tvalid,
  input  logic             out_tready,
  output stok_pkg::result_t out_res
);

  localparam int AW = $clog2(MAX_TOKEN);

  logic [7:0]          mem [2**(AW+1)];
  logic [7:0]          rd_data_r;

  stok_pkg::back_st_t  st_r, st_nxt;
  stok_pkg::cmd_t      cmd_r;
  stok_pkg::tok_len_t  pos_r, pos_nxt;
  logic                out_valid_r;
  stok_pkg::result_t   out_res_r, res_nxt;
  logic                out_free, out_load, emit_last;

  assign out_free  = !out_valid_r || out_tready;
  assign q_pop     = (st_r == stok_pkg::BK_IDLE) && q_valid;
  assign emit_last = ((pos_r + stok_pkg::tok_len_t'(1)) == cmd_r.flush_len);

  always_ff @(posedge clk) begin
    if (wr.en) mem[{wr.bank, wr.pos[AW-1:0]}] <= wr.data;
    rd_data_r <= mem[{cmd_r.flush_bank, pos_r[AW-1:0]}];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      stok_pkg::BK_IDLE: begin
        if (q_valid) begin
          unique case (q_data.first)
            stok_pkg::FK_FLUSH: st_nxt = stok_pkg::BK_FETCH;
            stok_pkg::FK_SLASH: st_nxt = stok_pkg::BK_SLASH;
            default:            st_nxt = stok_pkg::BK_SINGLE;
          endcase
        end
      end
      stok_pkg::BK_FETCH: st_nxt = stok_pkg::BK_EMIT;
      stok_pkg::BK_EMIT: begin
        if (out_free) begin
          if (!emit_last)            st_nxt = stok_pkg::BK_FETCH;
          else if (cmd_r.has_single) st_nxt = stok_pkg::BK_SINGLE;
          else                       st_nxt = stok_pkg::BK_IDLE;
        end
      end
      stok_pkg::BK_SLASH: begin
        if (out_free) st_nxt = cmd_r.has_single ? stok_pkg::BK_SINGLE : stok_pkg::BK_IDLE;
      end
      stok_pkg::BK_SINGLE: begin
        if (out_free) st_nxt = stok_pkg::BK_IDLE;
      end
      default: st_nxt = stok_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    out_load = 1'b0;
    res_nxt  = out_res_r;
    pos_nxt  = pos_r;
    rel      = '0;
    unique case (st_r)
      stok_pkg::BK_IDLE: pos_nxt = '0;
      stok_pkg::BK_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          res_nxt  = '{tok_type: cmd_r.flush_type, tok_char: rd_data_r, char_valid: 1'b1,
                       last: emit_last, err: stok_pkg::ERR_NONE};
          pos_nxt  = pos_r + stok_pkg::tok_len_t'(1);
          rel      = '{en: emit_last, bank: cmd_r.flush_bank};
        end
      end
      stok_pkg::BK_SLASH: begin
        if (out_free) begin
          out_load = 1'b1;
          res_nxt  = '{tok_type: stok_pkg::TT_SYMBOL, tok_char: stok_pkg::CH_SLASH,
                       char_valid: 1'b1, last: 1'b1, err: stok_pkg::ERR_NONE};
        end
      end
      stok_pkg::BK_SINGLE: begin
        if (out_free) begin
          out_load = 1'b1;
          res_nxt  = cmd_r.single;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_data;
    if (out_load) out_res_r <= res_nxt;
    pos_r <= pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= stok_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

`ifndef SYNTH
  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == stok_pkg::BK_EMIT) |-> (pos_r < cmd_r.flush_len))
    else $error("buffer read past token length");

  a_release_end: assert property (@(posedge clk) disable iff (!rst_n)
    rel.en |=> ((st_r == stok_pkg::BK_SINGLE) || (st_r == stok_pkg::BK_IDLE)))
    else $error("bank released before the flush ended");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.err != stok_pkg::ERR_NONE)) |->
      ((out_res_r.tok_char == 8'd0) && !out_res_r.last && !out_res_r.char_valid))
    else $error("error result carries token data");
`endif

endmodule

/* src/source_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_tokenizer
// Byte-stream lexer: one source byte per input transaction, one token
// character (or a character-less error or empty-string result) per output transaction.
// ----------------------------------------------------------------------------
// Path: a symbol or error result passes through the command queue, the
//   emitter state and the output register; each character of a flushed
//   word, integer or string is first read from the buffer (FETCH), then
//   loaded into the output register (EMIT).
// Throughput: one byte per cycle into the scanner while the two-entry queue
//   has room and the next buffer bank is free; the emitter reads each
//   buffered character, then loads it, before it fetches the next one.
// Reset: synchronous, active low; clears scan mode, counts and valid flags.
//   The token buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module source_tokenizer #(
  parameter int MAX_TOKEN = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] action (1 = end of text)
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] token_char, [9:8] error_code, rest zero
  output logic [3:0]  out_tuser,  // [2:0] token_type, [3] char_valid
  output logic        out_tlast   // last_of_token
);

  stok_pkg::cmd_t    push_cmd, pop_cmd;
  stok_pkg::wr_t     wr;
  stok_pkg::rel_t    rel;
  stok_pkg::result_t res;
  logic              push, q_ready, q_valid, q_pop;

  // Front: classify bytes, fill the buffer, issue commands.
  stok_front #(
    .MAX_TOKEN (MAX_TOKEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .cmd       (push_cmd),
    .q_ready   (q_ready),
    .wr        (wr),
    .rel       (rel)
  );

  // Decouple scanning from emission so each side can stall on its own.
  stok_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (pop_cmd)
  );

  // Back: replay buffered text and single results in order.
  stok_back #(
    .MAX_TOKEN (MAX_TOKEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .q_valid    (q_valid),
    .q_data     (pop_cmd),
    .q_pop      (q_pop),
    .rel        (rel),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  // Pack the result fields onto the stream ports.
  assign out_tdata = {6'b000000, res.err, res.tok_char};
  assign out_tuser = {res.char_valid, res.tok_type};
  assign out_tlast = res.last;

endmodule
